>>> hdl/gbtli_pkg.sv
// Shared constants, types and helper functions of the gyro look integrator.
package gbtli_pkg;

  // Angle format: signed, ANGLE_FRAC_BITS fraction bits, in radians.
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int ANG_W           = 20;

  // Field widths.
  localparam int FUNC_W   = 2;
  localparam int RATE_W   = 16;
  localparam int DT_W     = 16;
  localparam int KEYS_W   = 4;
  localparam int THR_W    = 12;
  localparam int BRATE_W  = 16;
  localparam int MSTEP_W  = 19;
  localparam int LRATE_W  = 16;
  localparam int BIAS_W   = 32;
  localparam int RATE_FRAC = 16;

  // Remainder after bias subtraction and serial accumulator widths.
  localparam int RES_W = RATE_W + RATE_FRAC + 1;
  localparam int ACC_W = RES_W + 1;

  // Degrees to radians, scaled by 2^32, walked one bit per cycle.
  localparam int                DEG_W       = 27;
  localparam logic [DEG_W-1:0]  DEG2RAD_Q32 = 27'd74961321;
  localparam int                STEP_SHIFT  = 52 - ANGLE_FRAC_BITS - DEG_W;

  // Look rate conversion from Q0.16 to the angle format.
  localparam int LOOK_UP = (ANGLE_FRAC_BITS >= 16) ? (ANGLE_FRAC_BITS - 16) : 0;
  localparam int LOOK_DN = (ANGLE_FRAC_BITS < 16) ? (16 - ANGLE_FRAC_BITS) : 1;
  localparam int LOOK_W  = LRATE_W + LOOK_UP;
  // Wide enough for an owed angle plus a look or frame turn of either sign.
  localparam int SUM_W   = ((LOOK_W > ANG_W) ? LOOK_W : ANG_W) + 2;

  localparam logic signed [ANG_W-1:0] ANG_MAX = {1'b0, {(ANG_W-1){1'b1}}};
  localparam logic signed [ANG_W-1:0] ANG_MIN = {1'b1, {(ANG_W-1){1'b0}}};

  // Item function codes.
  localparam logic [FUNC_W-1:0] FUNC_FRAME = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd2;

  // Configuration register indexes.
  localparam int                  CFG_IDX_W  = 2;
  localparam int                  CFG_DATA_W = MSTEP_W;
  localparam logic [CFG_IDX_W-1:0] REG_REST_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_RATE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_RATE       = 2'd3;

  localparam logic [THR_W-1:0]   RESET_REST_THRESHOLD = 12'd48;
  localparam logic [BRATE_W-1:0] RESET_BIAS_RATE      = 16'd1311;
  localparam logic [MSTEP_W-1:0] RESET_MAX_STEP       = 19'd39322;
  localparam logic [LRATE_W-1:0] RESET_KEY_RATE       = 16'd7209;

  typedef struct packed {
    logic [THR_W-1:0]   rest_threshold;
    logic [BRATE_W-1:0] bias_rate;
    logic [MSTEP_W-1:0] max_step;
    logic [LRATE_W-1:0] key_rate;
  } gbtli_cfg_t;

  // Status of one axis unit: idle once its frame work is done.
  typedef struct packed {
    logic                     idle;
    logic signed [ANG_W-1:0]  step;
  } gbtli_axis_res_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] delta_yaw;
    logic signed [ANG_W-1:0] delta_pitch;
    logic signed [ANG_W-1:0] owed_yaw_now;
    logic signed [ANG_W-1:0] owed_pitch_now;
  } gbtli_result_t;

  // Saturate a wide signed sum to the angle range.
  function automatic logic signed [ANG_W-1:0] sat_angle(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(ANG_MAX);
    lo = SUM_W'(ANG_MIN);
    if (v > hi) begin
      return ANG_MAX;
    end else if (v < lo) begin
      return ANG_MIN;
    end
    return v[ANG_W-1:0];
  endfunction

  // Look rate in the angle format; right shifts round half up.
  function automatic logic [LOOK_W-1:0] look_step(input logic [LRATE_W-1:0] lr);
    logic [LOOK_W:0] t;
    if (ANGLE_FRAC_BITS >= 16) begin
      t = (LOOK_W + 1)'(lr) << LOOK_UP;
    end else begin
      t = ((LOOK_W + 1)'(lr) + (LOOK_W + 1)'(1 << (LOOK_DN - 1))) >> LOOK_DN;
    end
    return t[LOOK_W-1:0];
  endfunction

endpackage

>>> hdl/gbtli_item_if.sv
// Input item channel of the gyro look integrator.
interface gbtli_item_if;
  import gbtli_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic                       gyro_on;
  logic                       sample_ready;
  logic signed [RATE_W-1:0]   rate_x;
  logic signed [RATE_W-1:0]   rate_y;
  logic [DT_W-1:0]            frame_time;
  logic [KEYS_W-1:0]          look_keys;
  logic signed [ANG_W-1:0]    load_yaw;
  logic signed [ANG_W-1:0]    load_pitch;

  modport source (
    output valid, func, gyro_on, sample_ready, rate_x, rate_y, frame_time,
           look_keys, load_yaw, load_pitch,
    input  ready
  );

  modport sink (
    input  valid, func, gyro_on, sample_ready, rate_x, rate_y, frame_time,
           look_keys, load_yaw, load_pitch,
    output ready
  );
endinterface

>>> hdl/gbtli_result_if.sv
// Result channel of the gyro look integrator.
interface gbtli_result_if;
  import gbtli_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ANG_W-1:0]  delta_yaw;
  logic signed [ANG_W-1:0]  delta_pitch;
  logic signed [ANG_W-1:0]  owed_yaw_now;
  logic signed [ANG_W-1:0]  owed_pitch_now;

  modport source (
    output valid, delta_yaw, delta_pitch, owed_yaw_now, owed_pitch_now,
    input  ready
  );

  modport sink (
    input  valid, delta_yaw, delta_pitch, owed_yaw_now, owed_pitch_now,
    output ready
  );
endinterface

>>> hdl/gbtli_cfg_if.sv
// Configuration write channel of the gyro look integrator.
interface gbtli_cfg_if;
  import gbtli_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

>>> hdl/gyro_bias_tracking_look_integrator_unit.sv
// Top level of the two-axis gyro look integrator with bias tracking.
//
// This block turns rate-gyro frames and look-key ticks into owed yaw and pitch
// angles in signed Q3.16 radians. A frame transaction (func 0) with the gyro on
// and a sample ready subtracts a tracked bias from each rate; a remainder under
// the rest threshold pulls that axis's bias toward the reading and turns it by
// zero, any other remainder is scaled by frame time and pi/180, clamped to the
// max step and added to the owed angle with saturation. A frame with the gyro
// off clears the owed angles, and one without a sample changes nothing. A look
// transaction (func 1) adds the held keys times the look rate to the owed
// angles, reports the saturated sums as deltas and clears the owed angles; a
// set transaction (func 2) loads them; func 3 only reports. Every input
// transaction yields exactly one result transaction. A new item is taken only
// once the last result has moved into the output register. A frame that reaches
// the axis units runs the bit-serial multiplier in each of them, which retires
// one multiplier bit per cycle: the 16 bits of frame time (or bias rate) and
// then, for an axis in motion, the 27 bits of the degree-to-radian constant; a
// frame with both axes at rest thus ends sooner, and every other item skips the
// axis units. A finished result sits in an output register, so the next item is
// accepted while the previous result waits to be taken. The configuration port
// is always ready and should be written only while the block is idle.
module gyro_bias_tracking_look_integrator_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  gbtli_item_if.sink      item_i,
  gbtli_result_if.source  result_o,
  gbtli_cfg_if.sink       cfg_i
);
  import gbtli_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_AXIS = 2'd1;
  localparam logic [1:0] ST_RES  = 2'd2;

  logic [1:0]               state_q, state_d;
  gbtli_cfg_t               cfg_q;
  logic signed [ANG_W-1:0]  owed_yaw_q, owed_yaw_d;
  logic signed [ANG_W-1:0]  owed_pitch_q, owed_pitch_d;
  gbtli_result_t            res_q, res_d;
  gbtli_result_t            out_q;
  logic                     out_valid_q;

  logic                     item_accept;
  logic                     axis_start;
  logic                     out_load;
  gbtli_axis_res_t          axis_yaw;
  gbtli_axis_res_t          axis_pitch;

  logic signed [SUM_W-1:0]  look_s;
  logic signed [SUM_W-1:0]  yaw_add;
  logic signed [SUM_W-1:0]  pitch_add;
  logic signed [ANG_W-1:0]  look_yaw;
  logic signed [ANG_W-1:0]  look_pitch;
  logic signed [ANG_W-1:0]  frame_yaw;
  logic signed [ANG_W-1:0]  frame_pitch;

  assign item_i.ready = (state_q == ST_IDLE);
  assign item_accept  = item_i.valid && item_i.ready;
  assign axis_start   = item_accept && (item_i.func == FUNC_FRAME) &&
                        item_i.gyro_on && item_i.sample_ready;

  // Both axes run the same serial state machine; each keeps its own bias.
  gbtli_axis u_axis_yaw (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (axis_start),
    .rate_i       (item_i.rate_x),
    .frame_time_i (item_i.frame_time),
    .cfg_i        (cfg_q),
    .res_o        (axis_yaw)
  );

  gbtli_axis u_axis_pitch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (axis_start),
    .rate_i       (item_i.rate_y),
    .frame_time_i (item_i.frame_time),
    .cfg_i        (cfg_q),
    .res_o        (axis_pitch)
  );

  // Look keys: right minus left turns yaw, down minus up turns pitch, so
  // opposite keys cancel.
  always_comb begin
    look_s = $signed(SUM_W'(look_step(cfg_q.key_rate)));

    if (item_i.look_keys[3] && !item_i.look_keys[2]) begin
      yaw_add = look_s;
    end else if (item_i.look_keys[2] && !item_i.look_keys[3]) begin
      yaw_add = -look_s;
    end else begin
      yaw_add = '0;
    end

    if (item_i.look_keys[1] && !item_i.look_keys[0]) begin
      pitch_add = look_s;
    end else if (item_i.look_keys[0] && !item_i.look_keys[1]) begin
      pitch_add = -look_s;
    end else begin
      pitch_add = '0;
    end

    look_yaw    = sat_angle(SUM_W'(owed_yaw_q) + yaw_add);
    look_pitch  = sat_angle(SUM_W'(owed_pitch_q) + pitch_add);
    frame_yaw   = sat_angle(SUM_W'(owed_yaw_q) + SUM_W'(axis_yaw.step));
    frame_pitch = sat_angle(SUM_W'(owed_pitch_q) + SUM_W'(axis_pitch.step));
  end

  // Result register handoff: a pending result moves into the output register
  // as soon as that register is empty or being drained.
  assign out_load = (state_q == ST_RES) && (!out_valid_q || result_o.ready);

  always_comb begin
    state_d      = state_q;
    owed_yaw_d   = owed_yaw_q;
    owed_pitch_d = owed_pitch_q;
    res_d        = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_accept) begin
          res_d.delta_yaw   = '0;
          res_d.delta_pitch = '0;
          state_d           = ST_RES;
          unique case (item_i.func)
            FUNC_FRAME: begin
              if (!item_i.gyro_on) begin
                owed_yaw_d   = '0;
                owed_pitch_d = '0;
              end else if (item_i.sample_ready) begin
                // The axis units now own the item until both go idle.
                state_d = ST_AXIS;
              end
            end
            FUNC_LOOK: begin
              res_d.delta_yaw   = look_yaw;
              res_d.delta_pitch = look_pitch;
              owed_yaw_d        = '0;
              owed_pitch_d      = '0;
            end
            FUNC_SET: begin
              owed_yaw_d   = item_i.load_yaw;
              owed_pitch_d = item_i.load_pitch;
            end
            default: begin
            end
          endcase
          res_d.owed_yaw_now   = owed_yaw_d;
          res_d.owed_pitch_now = owed_pitch_d;
        end
      end
      ST_AXIS: begin
        // Axis units leave idle on the start edge, so idle here means done.
        if (axis_yaw.idle && axis_pitch.idle) begin
          owed_yaw_d           = frame_yaw;
          owed_pitch_d         = frame_pitch;
          res_d.delta_yaw      = '0;
          res_d.delta_pitch    = '0;
          res_d.owed_yaw_now   = frame_yaw;
          res_d.owed_pitch_now = frame_pitch;
          state_d              = ST_RES;
        end
      end
      ST_RES: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      owed_yaw_q   <= '0;
      owed_pitch_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      owed_yaw_q   <= owed_yaw_d;
      owed_pitch_q <= owed_pitch_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rest_threshold <= RESET_REST_THRESHOLD;
      cfg_q.bias_rate      <= RESET_BIAS_RATE;
      cfg_q.max_step       <= RESET_MAX_STEP;
      cfg_q.key_rate       <= RESET_KEY_RATE;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_REST_THRESHOLD: cfg_q.rest_threshold <= cfg_i.data[THR_W-1:0];
        REG_BIAS_RATE:      cfg_q.bias_rate      <= cfg_i.data[BRATE_W-1:0];
        REG_MAX_STEP:       cfg_q.max_step       <= cfg_i.data[MSTEP_W-1:0];
        REG_KEY_RATE:       cfg_q.key_rate       <= cfg_i.data[LRATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.delta_yaw      = out_q.delta_yaw;
  assign result_o.delta_pitch    = out_q.delta_pitch;
  assign result_o.owed_yaw_now   = out_q.owed_yaw_now;
  assign result_o.owed_pitch_now = out_q.owed_pitch_now;

endmodule

>>> hdl/gbtli_axis.sv
// One gyro axis: bias tracking, rest detection and bit-serial rate scaling.
module gbtli_axis (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [gbtli_pkg::RATE_W-1:0]  rate_i,
  input  logic [gbtli_pkg::DT_W-1:0]           frame_time_i,
  input  gbtli_pkg::gbtli_cfg_t                cfg_i,
  output gbtli_pkg::gbtli_axis_res_t           res_o
);
  import gbtli_pkg::*;

  localparam int CNT_W      = $clog2(DEG_W);
  localparam int MUL1_STEPS = DT_W;
  localparam int STEP_RND_I = 1 << (STEP_SHIFT - 1);

  localparam logic [2:0] AX_IDLE  = 3'd0;
  localparam logic [2:0] AX_CHECK = 3'd1;
  localparam logic [2:0] AX_MUL1  = 3'd2;
  localparam logic [2:0] AX_MUL2  = 3'd3;
  localparam logic [2:0] AX_FIN   = 3'd4;

  localparam logic signed [BIAS_W-1:0] BIAS_MAX = {1'b0, {(BIAS_W-1){1'b1}}};
  localparam logic signed [BIAS_W-1:0] BIAS_MIN = {1'b1, {(BIAS_W-1){1'b0}}};

  logic [2:0]                 state_q, state_d;
  logic signed [BIAS_W-1:0]   bias_q, bias_d;
  logic signed [RES_W-1:0]    mcand_q, mcand_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic [DT_W-1:0]            b_q, b_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       rest_q, rest_d;
  logic signed [ANG_W-1:0]    step_q, step_d;

  logic signed [RES_W-1:0]    r_next;
  logic [RES_W-1:0]           r_mag;
  logic [RES_W-1:0]           thr_lim;
  logic                       is_rest;
  logic                       mul_bit;
  logic signed [ACC_W:0]      addend;
  logic signed [ACC_W:0]      acc_sum;
  logic signed [ACC_W:0]      bias_sum;
  logic signed [ACC_W:0]      bias_hi;
  logic signed [ACC_W:0]      bias_lo;
  logic signed [ACC_W:0]      rounded;
  logic signed [ACC_W:0]      scaled;
  logic signed [ACC_W:0]      ms_pos;
  logic signed [ACC_W:0]      ms_neg;
  logic signed [ACC_W:0]      clamped;

  always_comb begin
    // Rate is Q16.16 in 1/16 dps once the fraction bits are appended.
    r_next  = $signed({rate_i[RATE_W-1], rate_i, {RATE_FRAC{1'b0}}}) - RES_W'(bias_q);
    r_mag   = mcand_q[RES_W-1] ? RES_W'(-mcand_q) : RES_W'(mcand_q);
    thr_lim = RES_W'({cfg_i.rest_threshold, {RATE_FRAC{1'b0}}});
    is_rest = (r_mag < thr_lim);

    // LSB-first shift and add; every step halves the partial sum with floor.
    mul_bit = (state_q == AX_MUL2) ? DEG2RAD_Q32[cnt_q] : b_q[0];
    if (mul_bit) begin
      addend = (ACC_W + 1)'(mcand_q);
    end else begin
      addend = '0;
    end
    acc_sum = (ACC_W + 1)'(acc_q) + addend;

    bias_sum = (ACC_W + 1)'(bias_q) + (ACC_W + 1)'(acc_q);
    bias_hi  = (ACC_W + 1)'(BIAS_MAX);
    bias_lo  = (ACC_W + 1)'(BIAS_MIN);

    rounded = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(STEP_RND_I);
    scaled  = rounded >>> STEP_SHIFT;
    ms_pos  = $signed((ACC_W + 1)'(cfg_i.max_step));
    ms_neg  = -ms_pos;
    if (scaled > ms_pos) begin
      clamped = ms_pos;
    end else if (scaled < ms_neg) begin
      clamped = ms_neg;
    end else begin
      clamped = scaled;
    end
  end

  always_comb begin
    state_d = state_q;
    bias_d  = bias_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    b_d     = b_q;
    cnt_d   = cnt_q;
    rest_d  = rest_q;
    step_d  = step_q;
    unique case (state_q)
      AX_IDLE: begin
        if (start_i) begin
          mcand_d = r_next;
          b_d     = frame_time_i;
          state_d = AX_CHECK;
        end
      end
      AX_CHECK: begin
        rest_d = is_rest;
        if (is_rest) begin
          b_d = cfg_i.bias_rate;
        end
        acc_d   = '0;
        cnt_d   = '0;
        state_d = AX_MUL1;
      end
      AX_MUL1: begin
        acc_d = acc_sum[ACC_W:1];
        b_d   = b_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MUL1_STEPS - 1)) begin
          if (rest_q) begin
            state_d = AX_FIN;
          end else begin
            // The frame-time product, floored by 2^16, feeds the radian scaling.
            mcand_d = acc_sum[RES_W:1];
            acc_d   = '0;
            cnt_d   = '0;
            state_d = AX_MUL2;
          end
        end
      end
      AX_MUL2: begin
        acc_d = acc_sum[ACC_W:1];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DEG_W - 1)) begin
          state_d = AX_FIN;
        end
      end
      AX_FIN: begin
        if (rest_q) begin
          if (bias_sum > bias_hi) begin
            bias_d = BIAS_MAX;
          end else if (bias_sum < bias_lo) begin
            bias_d = BIAS_MIN;
          end else begin
            bias_d = bias_sum[BIAS_W-1:0];
          end
          step_d = '0;
        end else begin
          step_d = clamped[ANG_W-1:0];
        end
        state_d = AX_IDLE;
      end
      default: begin
        state_d = AX_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AX_IDLE;
      bias_q  <= '0;
    end else begin
      state_q <= state_d;
      bias_q  <= bias_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
    b_q     <= b_d;
    cnt_q   <= cnt_d;
    rest_q  <= rest_d;
    step_q  <= step_d;
  end

  assign res_o.idle = (state_q == AX_IDLE);
  assign res_o.step = step_q;

endmodule
